// ----- rtl/core/ps2md_pkg.sv -----
// Shared types, codes and constants of the PS/2 mouse packet decoder.
package ps2md_pkg;

  // Default ring size and the depth of the front-to-back command queue
  localparam int unsigned QUEUE_DEPTH_DEF = 32;
  localparam int unsigned FIFO_DEPTH      = 2;

  // Configuration port widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [2:0]  PACKET_BYTES_RST = 3'd3;
  localparam logic [15:0] BOUND_X_RST      = 16'd1280;
  localparam logic [15:0] BOUND_Y_RST      = 16'd800;

  // Bit positions inside the packet header and wheel byte
  localparam int unsigned SYNC_BIT   = 3;
  localparam int unsigned X_SIGN_BIT = 4;
  localparam int unsigned Y_SIGN_BIT = 5;
  localparam int unsigned BTN4_BIT   = 4;
  localparam int unsigned BTN5_BIT   = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE,
    CFG_PACKET_BYTES,
    CFG_FIVE_BUTTON,
    CFG_BOUND_X,
    CFG_BOUND_Y,
    CFG_SYNC_CHECK
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_DATA,
    OP_DELTA,
    OP_POP,
    OP_SET
  } op_e;

  // Command classes handed from the front to the back
  typedef enum logic [2:0] {
    CMD_TAKEN,
    CMD_IGNORED,
    CMD_NOT_READY,
    CMD_PACKET,
    CMD_DELTA,
    CMD_POP,
    CMD_SET
  } cmd_e;

  // Result kinds seen on the output channel
  typedef enum logic [3:0] {
    KIND_TAKEN,
    KIND_QUEUED,
    KIND_FULL,
    KIND_IGNORED,
    KIND_DELTA,
    KIND_EVENT,
    KIND_EMPTY,
    KIND_SET,
    KIND_NOT_READY
  } kind_e;

  typedef struct packed {
    logic        enable;
    logic [2:0]  packet_bytes;
    logic        five_button;
    logic [15:0] bound_x;
    logic [15:0] bound_y;
    logic        sync_check;
  } cfg_t;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [8:0]  dx;
    logic signed [9:0]  dy;
    logic signed [3:0]  dz;
    logic [4:0]         btn;
    logic [47:0]        tick;
    logic [15:0]        new_x;
    logic [15:0]        new_y;
  } cmd_t;

  // One ring entry: motion, buttons and timestamp
  typedef struct packed {
    logic signed [8:0]  dx;
    logic signed [9:0]  dy;
    logic signed [3:0]  dz;
    logic [4:0]         btn;
    logic [47:0]        tick;
  } event_t;

  localparam int unsigned EVENT_W = $bits(event_t);

endpackage

// ----- rtl/core/ps2_mouse_packet_decoder.sv -----
// Top level of the PS/2 mouse packet decoder: configuration registers and block wiring.
//
// Takes one item per clock cycle and gives one result for each item, in order. An item
// passes a front stage that assembles 3- or 4-byte packets and classifies the item, a
// two-entry command queue, and a back stage that updates the saturating delta sums, the
// clamped cursor and the event ring and loads the output register. The input stalls only
// when the command queue is full, which happens only while the output side stalls. The
// event ring is a RAM of QUEUE_DEPTH entries with one write and one registered read per
// cycle; it keeps at most QUEUE_DEPTH-1 events and needs no clearing after reset.
// Configuration writes are always taken (cfg_ready_o is tied high) and must only be
// issued while the block is idle.
module ps2_mouse_packet_decoder #(
  parameter int unsigned QUEUE_DEPTH = ps2md_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ps2md_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ps2md_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     operation_i,
  input  logic [7:0]                     data_byte_i,
  input  logic                           from_aux_i,
  input  logic [47:0]                    arrival_tick_i,
  input  logic [15:0]                    new_x_i,
  input  logic [15:0]                    new_y_i,
  // Result items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [3:0]                     kind_o,
  output logic signed [8:0]              move_dx_o,
  output logic signed [9:0]              move_dy_o,
  output logic signed [3:0]              move_dz_o,
  output logic [4:0]                     button_bits_o,
  output logic signed [31:0]             acc_dx_o,
  output logic signed [31:0]             acc_dy_o,
  output logic [15:0]                    pos_x_o,
  output logic [15:0]                    pos_y_o,
  output logic [47:0]                    event_tick_o
);

  ps2md_pkg::cfg_t cfg_q;
  ps2md_pkg::cmd_t front_cmd, back_cmd;
  logic            push, pop, fifo_full, fifo_empty;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable       <= 1'b0;
      cfg_q.packet_bytes <= ps2md_pkg::PACKET_BYTES_RST;
      cfg_q.five_button  <= 1'b0;
      cfg_q.bound_x      <= ps2md_pkg::BOUND_X_RST;
      cfg_q.bound_y      <= ps2md_pkg::BOUND_Y_RST;
      cfg_q.sync_check   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (ps2md_pkg::cfg_idx_e'(cfg_index_i))
        ps2md_pkg::CFG_ENABLE:       cfg_q.enable       <= cfg_data_i[0];
        ps2md_pkg::CFG_PACKET_BYTES: cfg_q.packet_bytes <= cfg_data_i[2:0];
        ps2md_pkg::CFG_FIVE_BUTTON:  cfg_q.five_button  <= cfg_data_i[0];
        ps2md_pkg::CFG_BOUND_X:      cfg_q.bound_x      <= cfg_data_i;
        ps2md_pkg::CFG_BOUND_Y:      cfg_q.bound_y      <= cfg_data_i;
        ps2md_pkg::CFG_SYNC_CHECK:   cfg_q.sync_check   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Accept and classify items
  ps2md_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .data_byte_i    (data_byte_i),
    .from_aux_i     (from_aux_i),
    .arrival_tick_i (arrival_tick_i),
    .new_x_i        (new_x_i),
    .new_y_i        (new_y_i),
    .fifo_full_i    (fifo_full),
    .push_o         (push),
    .cmd_o          (front_cmd)
  );

  // Decouple front and back
  ps2md_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .data_o  (back_cmd)
  );

  // Execute commands and drive results
  ps2md_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .fifo_empty_i  (fifo_empty),
    .cmd_i         (back_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .move_dx_o     (move_dx_o),
    .move_dy_o     (move_dy_o),
    .move_dz_o     (move_dz_o),
    .button_bits_o (button_bits_o),
    .acc_dx_o      (acc_dx_o),
    .acc_dy_o      (acc_dy_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .event_tick_o  (event_tick_o)
  );

endmodule

// ----- rtl/core/ps2md_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ps2md_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/ps2md_front.sv -----
// Front end: accepts items, assembles packets and classifies each item.
module ps2md_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ps2md_pkg::cfg_t   cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [7:0]        data_byte_i,
  input  logic              from_aux_i,
  input  logic [47:0]       arrival_tick_i,
  input  logic [15:0]       new_x_i,
  input  logic [15:0]       new_y_i,
  input  logic              fifo_full_i,
  output logic              push_o,
  output ps2md_pkg::cmd_t   cmd_o
);

  logic [1:0] byte_idx_q, byte_idx_d;
  logic [7:0] store_q [4];
  logic       accept;
  logic       store_we;
  logic       size4;
  logic       complete;
  logic       sync_bad;
  logic [7:0] b0, b1, b2, b3;
  logic signed [9:0] y_raw;

  assign in_stall_o = fifo_full_i;
  assign accept     = in_valid_i & ~fifo_full_i;
  assign push_o     = accept;

  // Packet size: 4 and above means wheel packets
  assign size4    = cfg_i.packet_bytes[2];
  assign complete = (byte_idx_q == 2'd3) || (byte_idx_q == 2'd2 && !size4);
  assign sync_bad = cfg_i.sync_check && (byte_idx_q == 2'd0) &&
                    !data_byte_i[ps2md_pkg::SYNC_BIT];

  // Take the byte arriving now in place of its not yet written slot
  assign b0 = store_q[0];
  assign b1 = (byte_idx_q == 2'd1) ? data_byte_i : store_q[1];
  assign b2 = (byte_idx_q == 2'd2) ? data_byte_i : store_q[2];
  assign b3 = (byte_idx_q == 2'd3) ? data_byte_i : store_q[3];
  assign y_raw = {b0[ps2md_pkg::Y_SIGN_BIT], b0[ps2md_pkg::Y_SIGN_BIT], b2};

  // Classify the item and decode a finished packet
  always_comb begin
    byte_idx_d  = byte_idx_q;
    store_we    = 1'b0;
    cmd_o.cmd   = ps2md_pkg::CMD_IGNORED;
    cmd_o.dx    = $signed({b0[ps2md_pkg::X_SIGN_BIT], b1});
    cmd_o.dy    = -y_raw;
    cmd_o.dz    = size4 ? $signed(b3[3:0]) : 4'sd0;
    cmd_o.btn   = {2'b00, b0[2:0]};
    if (size4 && cfg_i.five_button) begin
      cmd_o.btn[4:3] = {b3[ps2md_pkg::BTN5_BIT], b3[ps2md_pkg::BTN4_BIT]};
    end
    cmd_o.tick  = arrival_tick_i;
    cmd_o.new_x = new_x_i;
    cmd_o.new_y = new_y_i;
    unique case (ps2md_pkg::op_e'(operation_i))
      ps2md_pkg::OP_DATA: begin
        if (!cfg_i.enable) begin
          cmd_o.cmd = ps2md_pkg::CMD_NOT_READY;
        end else if (!from_aux_i || sync_bad) begin
          cmd_o.cmd = ps2md_pkg::CMD_IGNORED;
        end else begin
          store_we = 1'b1;
          if (complete) begin
            cmd_o.cmd  = ps2md_pkg::CMD_PACKET;
            byte_idx_d = 2'd0;
          end else begin
            cmd_o.cmd  = ps2md_pkg::CMD_TAKEN;
            byte_idx_d = byte_idx_q + 2'd1;
          end
        end
      end
      ps2md_pkg::OP_DELTA: begin
        cmd_o.cmd = cfg_i.enable ? ps2md_pkg::CMD_DELTA : ps2md_pkg::CMD_NOT_READY;
      end
      ps2md_pkg::OP_POP: begin
        cmd_o.cmd = ps2md_pkg::CMD_POP;
      end
      ps2md_pkg::OP_SET: begin
        cmd_o.cmd = ps2md_pkg::CMD_SET;
      end
      default: begin
        cmd_o.cmd = ps2md_pkg::CMD_IGNORED;
      end
    endcase
  end

  // Advance the byte position on accepted items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q <= 2'd0;
    end else if (accept) begin
      byte_idx_q <= byte_idx_d;
    end
  end

  // Hold packet bytes
  always_ff @(posedge clk_i) begin
    if (accept && store_we) begin
      store_q[byte_idx_q] <= data_byte_i;
    end
  end

endmodule

// ----- rtl/core/ps2md_fifo.sv -----
// Short command queue between the front and the back.
module ps2md_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ps2md_pkg::cmd_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output ps2md_pkg::cmd_t data_o
);

  localparam int unsigned PW = $clog2(ps2md_pkg::FIFO_DEPTH);
  localparam int unsigned CW = $clog2(ps2md_pkg::FIFO_DEPTH + 1);

  ps2md_pkg::cmd_t entries_q [ps2md_pkg::FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;

  assign full_o  = (count_q == CW'(ps2md_pkg::FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entries_q[rd_ptr_q];

  // Store incoming commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(ps2md_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(ps2md_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/ps2md_back.sv -----
// Back end: accumulates motion, moves the cursor, runs the event ring, drives results.
module ps2md_back #(
  parameter int unsigned QUEUE_DEPTH = ps2md_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ps2md_pkg::cfg_t   cfg_i,
  input  logic              fifo_empty_i,
  input  ps2md_pkg::cmd_t   cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        kind_o,
  output logic signed [8:0] move_dx_o,
  output logic signed [9:0] move_dy_o,
  output logic signed [3:0] move_dz_o,
  output logic [4:0]        button_bits_o,
  output logic signed [31:0] acc_dx_o,
  output logic signed [31:0] acc_dy_o,
  output logic [15:0]       pos_x_o,
  output logic [15:0]       pos_y_o,
  output logic [47:0]       event_tick_o
);

  localparam int unsigned RPW = $clog2(QUEUE_DEPTH);

  // Architectural state
  logic signed [31:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [4:0]         held_q, held_d;
  logic [15:0]        cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [RPW-1:0]     head_q, head_d, tail_q, tail_d;

  // Result register
  logic               out_valid_q;
  ps2md_pkg::kind_e   kind_q, kind_d;
  logic signed [8:0]  dx_q, dx_d;
  logic signed [9:0]  dy_q, dy_d;
  logic signed [3:0]  dz_q, dz_d;
  logic [4:0]         btn_q, btn_d;
  logic signed [31:0] accx_q, accx_d, accy_q, accy_d;

  logic               fire;
  logic [RPW-1:0]     head_inc, tail_inc;
  logic               ring_full, ring_empty;
  logic               ram_we, ram_re;
  logic signed [32:0] sx_sum, sy_sum;
  ps2md_pkg::event_t  wr_evt, rd_evt;
  logic [ps2md_pkg::EVENT_W-1:0] rd_word;

  // Add a motion to a coordinate and clamp it to [0, bound-1]
  function automatic logic [15:0] clamp_pos(input logic [15:0] cur,
                                            input logic signed [9:0] d,
                                            input logic [15:0] bound);
    logic signed [17:0] v;
    logic [15:0]        hi;
    v  = $signed({2'b00, cur}) + 18'(d);
    hi = (bound == 16'd0) ? 16'd0 : bound - 16'd1;
    if (v[17]) begin
      return 16'd0;
    end else if (v[16:0] > {1'b0, hi}) begin
      return hi;
    end else begin
      return v[15:0];
    end
  endfunction

  // Saturate a 33-bit sum to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [32:0] s);
    if (s[32] != s[31]) begin
      return s[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      return s[31:0];
    end
  endfunction

  assign fire  = !fifo_empty_i && (!out_valid_q || !out_stall_i);
  assign pop_o = fire;

  assign head_inc   = (head_q == RPW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc   = (tail_q == RPW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign ring_full  = (head_inc == tail_q);
  assign ring_empty = (head_q == tail_q);

  assign sx_sum = 33'(sum_x_q) + 33'(cmd_i.dx);
  assign sy_sum = 33'(sum_y_q) + 33'(cmd_i.dy);

  assign wr_evt.dx   = cmd_i.dx;
  assign wr_evt.dy   = cmd_i.dy;
  assign wr_evt.dz   = cmd_i.dz;
  assign wr_evt.btn  = cmd_i.btn;
  assign wr_evt.tick = cmd_i.tick;

  // Execute one command
  always_comb begin
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    held_d  = held_q;
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    head_d  = head_q;
    tail_d  = tail_q;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    kind_d  = ps2md_pkg::KIND_IGNORED;
    dx_d    = '0;
    dy_d    = '0;
    dz_d    = '0;
    btn_d   = '0;
    accx_d  = '0;
    accy_d  = '0;
    unique case (cmd_i.cmd)
      ps2md_pkg::CMD_TAKEN:     kind_d = ps2md_pkg::KIND_TAKEN;
      ps2md_pkg::CMD_IGNORED:   kind_d = ps2md_pkg::KIND_IGNORED;
      ps2md_pkg::CMD_NOT_READY: kind_d = ps2md_pkg::KIND_NOT_READY;
      ps2md_pkg::CMD_PACKET: begin
        dx_d    = cmd_i.dx;
        dy_d    = cmd_i.dy;
        dz_d    = cmd_i.dz;
        btn_d   = cmd_i.btn;
        sum_x_d = sat32(sx_sum);
        sum_y_d = sat32(sy_sum);
        held_d  = cmd_i.btn;
        cur_x_d = clamp_pos(cur_x_q, 10'(cmd_i.dx), cfg_i.bound_x);
        cur_y_d = clamp_pos(cur_y_q, cmd_i.dy, cfg_i.bound_y);
        if (ring_full) begin
          kind_d = ps2md_pkg::KIND_FULL;
        end else begin
          kind_d = ps2md_pkg::KIND_QUEUED;
          ram_we = 1'b1;
          head_d = head_inc;
        end
      end
      ps2md_pkg::CMD_DELTA: begin
        kind_d  = ps2md_pkg::KIND_DELTA;
        accx_d  = sum_x_q;
        accy_d  = sum_y_q;
        btn_d   = held_q;
        sum_x_d = '0;
        sum_y_d = '0;
      end
      ps2md_pkg::CMD_POP: begin
        if (ring_empty) begin
          kind_d = ps2md_pkg::KIND_EMPTY;
        end else begin
          kind_d = ps2md_pkg::KIND_EVENT;
          ram_re = 1'b1;
          tail_d = tail_inc;
        end
      end
      ps2md_pkg::CMD_SET: begin
        kind_d  = ps2md_pkg::KIND_SET;
        cur_x_d = cmd_i.new_x;
        cur_y_d = cmd_i.new_y;
      end
      default: kind_d = ps2md_pkg::KIND_IGNORED;
    endcase
  end

  // Update state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      held_q      <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        sum_x_q     <= sum_x_d;
        sum_y_q     <= sum_y_d;
        held_q      <= held_d;
        cur_x_q     <= cur_x_d;
        cur_y_q     <= cur_y_d;
        head_q      <= head_d;
        tail_q      <= tail_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      kind_q <= kind_d;
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      dz_q   <= dz_d;
      btn_q  <= btn_d;
      accx_q <= accx_d;
      accy_q <= accy_d;
    end
  end

  // Event ring storage
  ps2md_ram #(
    .WIDTH (ps2md_pkg::EVENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (fire && ram_we),
    .wr_addr_i (head_q),
    .wr_data_i (wr_evt),
    .rd_en_i   (fire && ram_re),
    .rd_addr_i (tail_q),
    .rd_data_o (rd_word)
  );

  assign rd_evt = ps2md_pkg::event_t'(rd_word);

  // Drive results, popped events come straight from the ring read data
  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign move_dx_o     = (kind_q == ps2md_pkg::KIND_EVENT) ? rd_evt.dx   : dx_q;
  assign move_dy_o     = (kind_q == ps2md_pkg::KIND_EVENT) ? rd_evt.dy   : dy_q;
  assign move_dz_o     = (kind_q == ps2md_pkg::KIND_EVENT) ? rd_evt.dz   : dz_q;
  assign button_bits_o = (kind_q == ps2md_pkg::KIND_EVENT) ? rd_evt.btn  : btn_q;
  assign event_tick_o  = (kind_q == ps2md_pkg::KIND_EVENT) ? rd_evt.tick : 48'd0;
  assign acc_dx_o      = accx_q;
  assign acc_dy_o      = accy_q;
  assign pos_x_o       = cur_x_q;
  assign pos_y_o       = cur_y_q;

endmodule
